@@ rtl/cor_pkg.sv @@
package cor_pkg;

  localparam int POS_W  = 18;
  localparam int RAD_W  = 16;
  localparam int SUM_W  = RAD_W + 1;
  localparam int MAG_W  = SUM_W;
  localparam int SQ_W   = 2 * SUM_W;
  localparam int ROOT_W = SUM_W;
  localparam int REM_W  = ROOT_W + 2;
  localparam int NUM_W  = 36;
  localparam int DEN_W  = ROOT_W + 3;
  localparam int Q_W    = 17;

  localparam logic signed [POS_W+1:0] POS_MAX = 20'sd131071;
  localparam logic signed [POS_W+1:0] POS_MIN = -20'sd131072;

  typedef struct packed {
    logic signed [POS_W-1:0] x1;
    logic signed [POS_W-1:0] y1;
    logic signed [POS_W-1:0] x2;
    logic signed [POS_W-1:0] y2;
    logic                    neg_x;
    logic                    neg_y;
    logic [MAG_W-1:0]        mag_x;
    logic [MAG_W-1:0]        mag_y;
    logic [SUM_W-1:0]        sum;
    logic                    hit;
    logic                    same;
  } pass_t;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W+1:0] v);
    logic signed [POS_W-1:0] r;
    if (v > POS_MAX) r = POS_MAX[POS_W-1:0];
    else if (v < POS_MIN) r = POS_MIN[POS_W-1:0];
    else r = v[POS_W-1:0];
    return r;
  endfunction

endpackage

@@ rtl/cor_front.sv @@
module cor_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_v,
  input  logic signed [cor_pkg::POS_W-1:0] first_x,
  input  logic signed [cor_pkg::POS_W-1:0] first_y,
  input  logic [cor_pkg::RAD_W-1:0]   first_radius,
  input  logic signed [cor_pkg::POS_W-1:0] second_x,
  input  logic signed [cor_pkg::POS_W-1:0] second_y,
  input  logic [cor_pkg::RAD_W-1:0]   second_radius,
  output logic                        out_v,
  output cor_pkg::pass_t              out_p,
  output logic [cor_pkg::SQ_W-1:0]    root_in
);
  import cor_pkg::*;

  // stage 1: differences and radius sum
  logic                    v1;
  pass_t                   p1;
  logic [POS_W-1:0]        adx1, ady1;
  // stage 2: squares
  logic                    v2;
  pass_t                   p2;
  logic [2*POS_W-1:0]      sqx2, sqy2;
  logic [SQ_W-1:0]         ssq2;

  logic signed [POS_W:0]   dx, dy;
  logic [POS_W-1:0]        adx, ady;
  logic [2*POS_W:0]        dist2;
  logic                    hit, same;
  pass_t                   p3;

  always_comb begin
    dx = {first_x[POS_W-1], first_x} - {second_x[POS_W-1], second_x};
    dy = {first_y[POS_W-1], first_y} - {second_y[POS_W-1], second_y};
    adx = dx[POS_W] ? POS_W'(-dx) : dx[POS_W-1:0];
    ady = dy[POS_W] ? POS_W'(-dy) : dy[POS_W-1:0];
    dist2 = {1'b0, sqx2} + {1'b0, sqy2};
    hit = dist2 < {{(2*POS_W+1-SQ_W){1'b0}}, ssq2};
    same = hit && (dist2 == '0);
    p3 = p2;
    p3.hit = hit;
    p3.same = same;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      v1 <= in_v;
      v2 <= v1;
      out_v <= v2;
    end
    if (en) begin
      p1.x1 <= first_x;
      p1.y1 <= first_y;
      p1.x2 <= second_x;
      p1.y2 <= second_y;
      p1.neg_x <= dx[POS_W];
      p1.neg_y <= dy[POS_W];
      p1.mag_x <= adx[MAG_W-1:0];
      p1.mag_y <= ady[MAG_W-1:0];
      p1.sum <= {1'b0, first_radius} + {1'b0, second_radius};
      p1.hit <= 1'b0;
      p1.same <= 1'b0;
      adx1 <= adx;
      ady1 <= ady;
      p2 <= p1;
      sqx2 <= adx1 * adx1;
      sqy2 <= ady1 * ady1;
      ssq2 <= p1.sum * p1.sum;
      out_p <= p3;
      root_in <= (hit && !same) ? dist2[SQ_W-1:0] : '0;
    end
  end

endmodule

@@ rtl/cor_sqrt.sv @@
module cor_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_v,
  input  cor_pkg::pass_t             in_p,
  input  logic [cor_pkg::SQ_W-1:0]   n_in,
  output logic                       out_v,
  output cor_pkg::pass_t             out_p,
  output logic [cor_pkg::ROOT_W-1:0] root
);
  import cor_pkg::*;

  localparam int STEPS = ROOT_W;

  logic              v    [0:STEPS-1];
  pass_t             p    [0:STEPS-1];
  logic [SQ_W-1:0]   n    [0:STEPS-1];
  logic [REM_W-1:0]  rem  [0:STEPS-1];
  logic [ROOT_W-1:0] rt   [0:STEPS-1];

  // one result bit per stage, two radicand bits brought down each time
  for (genvar s = 0; s < STEPS; s++) begin : g_step
    localparam int B = STEPS - 1 - s;
    logic              v_c;
    pass_t             p_c;
    logic [SQ_W-1:0]   n_c;
    logic [REM_W-1:0]  rem_c;
    logic [ROOT_W-1:0] rt_c;
    logic [REM_W+1:0]  trial, t;
    logic              ge;

    if (s == 0) begin : g_first
      assign v_c = in_v;
      assign p_c = in_p;
      assign n_c = n_in;
      assign rem_c = '0;
      assign rt_c = '0;
    end else begin : g_rest
      assign v_c = v[s-1];
      assign p_c = p[s-1];
      assign n_c = n[s-1];
      assign rem_c = rem[s-1];
      assign rt_c = rt[s-1];
    end

    always_comb begin
      trial = {rem_c, n_c[2*B+1 -: 2]};
      t = {2'b00, rt_c, 2'b01};
      ge = trial >= t;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (en) begin
        v[s] <= v_c;
      end
      if (en) begin
        p[s] <= p_c;
        n[s] <= n_c;
        rem[s] <= ge ? REM_W'(trial - t) : trial[REM_W-1:0];
        rt[s] <= {rt_c[ROOT_W-2:0], ge};
      end
    end
  end

  assign out_v = v[STEPS-1];
  assign out_p = p[STEPS-1];
  assign root = rt[STEPS-1];

endmodule

@@ rtl/cor_div.sv @@
module cor_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_v,
  input  cor_pkg::pass_t             in_p,
  input  logic [cor_pkg::ROOT_W-1:0] root,
  output logic                       out_v,
  output cor_pkg::pass_t             out_p,
  output logic [cor_pkg::Q_W-1:0]    q_x,
  output logic [cor_pkg::Q_W-1:0]    q_y
);
  import cor_pkg::*;

  localparam int STEPS = Q_W;

  // product stage
  logic               mv;
  pass_t              mp;
  logic [ROOT_W-1:0]  md;
  logic [2*MAG_W-1:0] prod [0:1];
  // numerator stage
  logic               nv;
  pass_t              np;
  logic [DEN_W-1:0]   nden;
  logic [NUM_W-1:0]   num [0:1];

  logic [SUM_W-1:0]   gap;
  assign gap = in_p.sum - root;

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0;
      nv <= 1'b0;
    end else if (en) begin
      mv <= in_v;
      nv <= mv;
    end
    if (en) begin
      mp <= in_p;
      md <= root;
      prod[0] <= in_p.mag_x * gap;
      prod[1] <= in_p.mag_y * gap;
      np <= mp;
      nden <= {md, 3'b000};
      // 3*mag*gap plus half the divisor for round to nearest
      for (int l = 0; l < 2; l++) begin
        num[l] <= NUM_W'({prod[l], 1'b0}) + NUM_W'(prod[l]) + NUM_W'({md, 2'b00});
      end
    end
  end

  logic             v   [0:STEPS-1];
  pass_t            p   [0:STEPS-1];
  logic [DEN_W-1:0] den [0:STEPS-1];
  logic [NUM_W-1:0] rem [0:STEPS-1][0:1];
  logic [Q_W-1:0]   q   [0:STEPS-1][0:1];

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    localparam int K = STEPS - 1 - s;
    logic             v_c;
    pass_t            p_c;
    logic [DEN_W-1:0] den_c;
    logic [NUM_W-1:0] rem_c [0:1];
    logic [Q_W-1:0]   q_c   [0:1];
    logic [NUM_W-1:0] sub;

    if (s == 0) begin : g_first
      assign v_c = nv;
      assign p_c = np;
      assign den_c = nden;
      assign rem_c[0] = num[0];
      assign rem_c[1] = num[1];
      assign q_c[0] = '0;
      assign q_c[1] = '0;
    end else begin : g_rest
      assign v_c = v[s-1];
      assign p_c = p[s-1];
      assign den_c = den[s-1];
      assign rem_c[0] = rem[s-1][0];
      assign rem_c[1] = rem[s-1][1];
      assign q_c[0] = q[s-1][0];
      assign q_c[1] = q[s-1][1];
    end

    assign sub = NUM_W'(den_c) << K;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (en) begin
        v[s] <= v_c;
      end
      if (en) begin
        p[s] <= p_c;
        den[s] <= den_c;
        for (int l = 0; l < 2; l++) begin
          rem[s][l] <= (rem_c[l] >= sub) ? rem_c[l] - sub : rem_c[l];
          q[s][l] <= {q_c[l][Q_W-2:0], rem_c[l] >= sub};
        end
      end
    end
  end

  assign out_v = v[STEPS-1];
  assign out_p = p[STEPS-1];
  assign q_x = q[STEPS-1][0];
  assign q_y = q[STEPS-1][1];

endmodule

@@ rtl/circle_overlap_resolve.sv @@
// Position correction for pairs of overlapping circles.
// Input channel: valid/stall with first_x, first_y, first_radius, second_x,
// second_y, second_radius. An item is taken on a clock edge with valid high
// and stall low. Output channel: result_valid/result_stall with the moved
// centres, the overlapped flag and the coincident flag, one result per item.
// Throughput is one item per cycle while result_stall does not hold it. From the
// accepting edge to result_valid an item passes 3 front stages (difference,
// squares, overlap test), 17 square-root stages (one root bit each), 2 stages
// for the product and rounded numerator, 17 divider stages (one quotient bit
// each, both axes in parallel) and the output register.
// The whole pipeline moves together: while result_valid is high and the
// receiver holds result_stall, every stage holds and stall is raised on the
// input channel, so nothing is lost or repeated. Bubbles travel with valid
// bits. A synchronous rst clears all valid bits; no other state is kept.
module circle_overlap_resolve (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             valid,
  output logic                             stall,
  input  logic signed [cor_pkg::POS_W-1:0] first_x,
  input  logic signed [cor_pkg::POS_W-1:0] first_y,
  input  logic [cor_pkg::RAD_W-1:0]        first_radius,
  input  logic signed [cor_pkg::POS_W-1:0] second_x,
  input  logic signed [cor_pkg::POS_W-1:0] second_y,
  input  logic [cor_pkg::RAD_W-1:0]        second_radius,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic signed [cor_pkg::POS_W-1:0] new_first_x,
  output logic signed [cor_pkg::POS_W-1:0] new_first_y,
  output logic signed [cor_pkg::POS_W-1:0] new_second_x,
  output logic signed [cor_pkg::POS_W-1:0] new_second_y,
  output logic                             overlapped,
  output logic                             coincident
);
  import cor_pkg::*;

  logic              en;
  logic              f_v, s_v, d_v;
  pass_t             f_p, s_p, d_p;
  logic [SQ_W-1:0]   root_in;
  logic [ROOT_W-1:0] root;
  logic [Q_W-1:0]    q_x, q_y;

  assign en = !(result_valid && result_stall);
  assign stall = !en;

  cor_front u_front (
    .clk, .rst, .en,
    .in_v(valid && !stall),
    .first_x, .first_y, .first_radius,
    .second_x, .second_y, .second_radius,
    .out_v(f_v), .out_p(f_p), .root_in
  );

  cor_sqrt u_sqrt (
    .clk, .rst, .en,
    .in_v(f_v), .in_p(f_p), .n_in(root_in),
    .out_v(s_v), .out_p(s_p), .root
  );

  cor_div u_div (
    .clk, .rst, .en,
    .in_v(s_v), .in_p(s_p), .root,
    .out_v(d_v), .out_p(d_p), .q_x, .q_y
  );

  logic signed [POS_W+1:0] px, py;
  logic                    move;

  always_comb begin
    px = d_p.neg_x ? -$signed({3'b000, q_x}) : $signed({3'b000, q_x});
    py = d_p.neg_y ? -$signed({3'b000, q_y}) : $signed({3'b000, q_y});
    move = d_p.hit && !d_p.same;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= d_v;
    end
    if (en) begin
      new_first_x <= move ? sat_pos(20'(d_p.x1) + px) : d_p.x1;
      new_first_y <= move ? sat_pos(20'(d_p.y1) + py) : d_p.y1;
      new_second_x <= move ? sat_pos(20'(d_p.x2) - px) : d_p.x2;
      new_second_y <= move ? sat_pos(20'(d_p.y2) - py) : d_p.y2;
      overlapped <= d_p.hit;
      coincident <= d_p.same;
    end
  end

  a_same_implies_hit: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!coincident || overlapped))
    else $error("coincident result without overlap");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  a_div_holds: assert property (@(posedge clk) disable iff (rst)
    (d_v && !en) |=> d_v)
    else $error("divider output lost while stalled");

  a_stall_from_output: assert property (@(posedge clk) disable iff (rst)
    stall |-> result_valid)
    else $error("input stalled with empty output");

endmodule

@@ verif/circle_overlap_resolve_test.sv @@
module circle_overlap_resolve_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cor_pkg::*;

  typedef struct {
    logic signed [POS_W-1:0] fx, fy, sx, sy;
    logic hit, same;
  } pair_result_t;

  class overlap_scoreboard;
    pair_result_t pending[$];
    int errors;

    function automatic longint isqrt(longint n);
      longint r, lo, hi, m;
      lo = 0;
      hi = 3000000;
      while (lo < hi) begin
        m = (lo + hi + 1) / 2;
        if (m * m <= n) lo = m;
        else hi = m - 1;
      end
      r = lo;
      return r;
    endfunction

    function automatic longint push(longint delta, longint gap, longint d);
      longint mag, q;
      mag = delta < 0 ? -delta : delta;
      q = (3 * mag * gap + 4 * d) / (8 * d);
      return delta < 0 ? -q : q;
    endfunction

    function automatic logic signed [POS_W-1:0] clamp(longint v);
      if (v > 131071) return 18'sd131071;
      if (v < -131072) return 18'sh20000;
      return v[POS_W-1:0];
    endfunction

    function void note_pair(longint x1, longint y1, longint r1,
                            longint x2, longint y2, longint r2);
      pair_result_t e;
      longint dx, dy, dist2, s, d, px, py;
      dx = x1 - x2;
      dy = y1 - y2;
      dist2 = dx * dx + dy * dy;
      s = r1 + r2;
      e.fx = x1[POS_W-1:0]; e.fy = y1[POS_W-1:0];
      e.sx = x2[POS_W-1:0]; e.sy = y2[POS_W-1:0];
      e.hit = 0; e.same = 0;
      if (dist2 < s * s) begin
        e.hit = 1;
        if (dist2 == 0) e.same = 1;
        else begin
          d = isqrt(dist2);
          px = push(dx, s - d, d);
          py = push(dy, s - d, d);
          e.fx = clamp(x1 + px); e.fy = clamp(y1 + py);
          e.sx = clamp(x2 - px); e.sy = clamp(y2 - py);
        end
      end
      pending.push_back(e);
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
    endtask

    task check_result(pair_result_t r);
      pair_result_t e;
      if (pending.size() == 0) begin
        report("unexpected item", 1, 0);
        return;
      end
      e = pending.pop_front();
      if (r.fx !== e.fx) report("new_first_x", r.fx, e.fx);
      if (r.fy !== e.fy) report("new_first_y", r.fy, e.fy);
      if (r.sx !== e.sx) report("new_second_x", r.sx, e.sx);
      if (r.sy !== e.sy) report("new_second_y", r.sy, e.sy);
      if (r.hit !== e.hit) report("overlapped", r.hit, e.hit);
      if (r.same !== e.same) report("coincident", r.same, e.same);
    endtask
  endclass

  logic clk = 0, rst = 1;
  logic valid = 0, result_stall = 0;
  logic stall, result_valid, overlapped, coincident;
  logic signed [POS_W-1:0] first_x = 0, first_y = 0, second_x = 0, second_y = 0;
  logic [RAD_W-1:0] first_radius = 0, second_radius = 0;
  logic signed [POS_W-1:0] new_first_x, new_first_y, new_second_x, new_second_y;

  overlap_scoreboard board = new();
  int send_idle_pct = 0, recv_stall_pct = 0;
  bit hold_off = 0, done = 0;
  int quiet = 0;

  circle_overlap_resolve u_top (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // receiver side and result check
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      pair_result_t r;
      r.fx = new_first_x; r.fy = new_first_y;
      r.sx = new_second_x; r.sy = new_second_y;
      r.hit = overlapped; r.same = coincident;
      board.check_result(r);
    end
    result_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((valid && !stall) || (result_valid && !result_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 5000) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_pair(logic signed [POS_W-1:0] x1, y1, logic [RAD_W-1:0] r1,
                           logic signed [POS_W-1:0] x2, y2, logic [RAD_W-1:0] r2);
    while ($urandom_range(99) < send_idle_pct) begin
      valid <= 0;
      @(posedge clk);
    end
    valid <= 1;
    first_x <= x1; first_y <= y1; first_radius <= r1;
    second_x <= x2; second_y <= y2; second_radius <= r2;
    @(posedge clk);
    while (stall) @(posedge clk);
    board.note_pair(x1, y1, r1, x2, y2, r2);
  endtask

  task automatic send_random();
    logic signed [POS_W-1:0] x1, y1, x2, y2;
    logic [RAD_W-1:0] r1, r2;
    int kind;
    kind = $urandom_range(9);
    x1 = POS_W'($urandom); y1 = POS_W'($urandom);
    r1 = RAD_W'($urandom); r2 = RAD_W'($urandom);
    if (kind < 7) begin
      // near pair, usually overlapping
      x2 = x1 + $signed(18'($urandom_range(0, 262143) >> $urandom_range(1, 17)));
      y2 = y1 - $signed(18'($urandom_range(0, 262143) >> $urandom_range(1, 17)));
    end else if (kind == 7) begin
      x2 = x1; y2 = y1;
    end else begin
      x2 = POS_W'($urandom); y2 = POS_W'($urandom);
    end
    send_pair(x1, y1, r1, x2, y2, r2);
  endtask

  task automatic drain();
    valid <= 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed corners
    send_pair(0, 0, 0, 0, 0, 0);
    send_pair(0, 0, 16'hffff, 0, 0, 16'hffff);
    send_pair(0, 0, 16'h8000, 18'sd65536, 0, 16'h8000);
    send_pair(0, 0, 16'h8000, 18'sd65535, 0, 16'h8000);
    send_pair(18'sd131071, 18'sd131071, 16'hffff, 18'sd131070, 18'sd131070, 16'hffff);
    send_pair(18'sh20000, 18'sh20000, 16'hffff, -18'sd131071, -18'sd131071, 16'hffff);
    send_pair(18'sd131071, 18'sh20000, 16'hffff, 18'sd131070, -18'sd131071, 16'h0);
    send_pair(5, 7, 16'hffff, 5, 7, 1);
    send_pair(0, 0, 1, 1, 0, 1);
    send_pair(0, 0, 16'hffff, 18'sd131071, 18'sd131071, 16'hffff);
    send_pair(18'sh20000, 18'sd131071, 16'hffff, 18'sd131071, 18'sh20000, 16'hffff);
    send_pair(100, -3, 16'h1234, -50, 40, 16'h4321);
    send_pair(3, 4, 3, 0, 0, 3);
    send_pair(18'sh2aaaa, 18'sh15555, 16'haaaa, 18'sh2aaab, 18'sh15554, 16'h5555);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? 54 : 0;
      recv_stall_pct = (ph == 2) ? 54 : (ph == 3 ? 13 : 0);
      if (ph == 3) send_idle_pct = 13;
      for (int i = 0; i < 280; i++) begin
        if (ph == 0 && i == 100) begin
          fork
            begin
              hold_off = 1;
              repeat (150) @(posedge clk);
              hold_off = 0;
            end
          join_none
        end
        send_random();
        if (i % 5 == 4) begin
          int gap;
          gap = $urandom_range(3);
          if (gap != 0) begin
            valid <= 0;
            repeat (gap) @(posedge clk);
          end
        end
      end
      drain();
    end
    repeat (60) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
